@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KFPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kfpu check failed");

// Next-cycle implication, checked out of reset.
`define KFPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kfpu check failed");

`endif

@@ hw/rtl/kfpu_pkg.sv @@
package kfpu_pkg;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;

  localparam int DEF_STATE_DIM = 4;
  localparam int DEF_MEAS_DIM  = 2;
  localparam int DEF_FRAC_BITS = 16;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_PRED = 2'd1;
  localparam logic [1:0] KIND_UPD  = 2'd2;

  localparam logic [2:0] SEL_TRANS = 3'd0;
  localparam logic [2:0] SEL_PNOISE = 3'd1;
  localparam logic [2:0] SEL_MEAS  = 3'd2;
  localparam logic [2:0] SEL_MNOISE = 3'd3;
  localparam logic [2:0] SEL_COV   = 3'd4;
  localparam logic [2:0] SEL_STATE = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SING = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef struct packed {
    logic init;
    logic mul;
    logic acc;
    logic sub;
  } mac_ctl_t;

endpackage

@@ hw/rtl/kalman_filter_predict_update_top.sv @@
// Linear Kalman filter, signed Q16.16, state and matrices in one state memory.
// Input channel (in_valid/in_ready) takes one word per item: a load of one
// matrix or state entry, a predict, or a measurement update with in_meas_*.
// Result channel (out_valid/out_ready) returns one word per item: the first
// four state elements after the item and a status (ok, singular, saturated).
// Items run one at a time. Every product steps through the states S_RA,
// S_RB, S_MUL and S_ACC, using the state memory (one read port, one write
// port) and the shared multiply-accumulate unit; each stored element also
// passes S_INIT, S_INITW when its start value is read from memory, and
// S_FIN. In an update the gain uses one radix-2 divide per element.
// in_ready is high only while no item is in work. A finished result sits in
// the output register until taken; the next item may be accepted meanwhile,
// and its result waits for the register to free up.
// Reset (rst_n low, synchronous) clears state, covariance and all matrices
// to zero through per-entry valid bits; no clearing pass is needed.
`include "assert_macros.svh"

module kalman_filter_predict_update_top #(
  parameter int STATE_DIM = kfpu_pkg::DEF_STATE_DIM,
  parameter int MEAS_DIM  = kfpu_pkg::DEF_MEAS_DIM,
  parameter int FRAC_BITS = kfpu_pkg::DEF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_kind,
  input  logic [2:0]      in_matrix_select,
  input  logic [1:0]      in_row_index,
  input  logic [1:0]      in_col_index,
  input  kfpu_pkg::word_t in_load_value,
  input  kfpu_pkg::word_t in_meas_first,
  input  kfpu_pkg::word_t in_meas_second,
  output logic            out_valid,
  input  logic            out_ready,
  output kfpu_pkg::word_t out_est_pos_x,
  output kfpu_pkg::word_t out_est_pos_y,
  output kfpu_pkg::word_t out_est_vel_x,
  output kfpu_pkg::word_t out_est_vel_y,
  output logic [1:0]      out_status
);
  import kfpu_pkg::*;

  localparam int N  = STATE_DIM;
  localparam int M  = MEAS_DIM;
  localparam int NN = N * N;
  localparam int NM = N * M;
  localparam int MM = M * M;

  localparam int A_F    = 0;
  localparam int A_Q    = NN;
  localparam int A_H    = 2 * NN;
  localparam int A_R    = A_H + NM;
  localparam int A_P    = A_R + MM;
  localparam int A_X    = A_P + NN;
  localparam int USER_D = A_X + N;
  localparam int A_FX   = USER_D;
  localparam int A_FP   = A_FX + N;
  localparam int A_PH   = A_FP + NN;
  localparam int A_S    = A_PH + NM;
  localparam int A_K    = A_S + MM;
  localparam int A_IKH  = A_K + NM;
  localparam int A_NP   = A_IKH + NN;
  localparam int A_Y    = A_NP + NN;
  localparam int RAM_D  = A_Y + M;
  localparam int AW     = $clog2(RAM_D);
  localparam int UW     = $clog2(USER_D);
  localparam int CW     = $clog2(N + 1);
  localparam int XS     = (N < 4) ? N : 4;

  localparam word_t ONE_Q = 32'sd1 <<< FRAC_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_INITW = 4'd3;
  localparam logic [3:0] S_RA    = 4'd4;
  localparam logic [3:0] S_RB    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [3:0] PH_FX  = 4'd0;
  localparam logic [3:0] PH_FP  = 4'd1;
  localparam logic [3:0] PH_PP  = 4'd2;
  localparam logic [3:0] PH_XC  = 4'd3;
  localparam logic [3:0] PH_Y   = 4'd4;
  localparam logic [3:0] PH_PH  = 4'd5;
  localparam logic [3:0] PH_S   = 4'd6;
  localparam logic [3:0] PH_DET = 4'd7;
  localparam logic [3:0] PH_K   = 4'd8;
  localparam logic [3:0] PH_IKH = 4'd9;
  localparam logic [3:0] PH_NP  = 4'd10;
  localparam logic [3:0] PH_XU  = 4'd11;
  localparam logic [3:0] PH_PC  = 4'd12;

  localparam logic [1:0] B_MEM = 2'd0;
  localparam logic [1:0] B_ADJ = 2'd1;
  localparam logic [1:0] B_ONE = 2'd2;
  localparam logic [1:0] B_DET = 2'd3;

  localparam logic [1:0] I_ZERO = 2'd0;
  localparam logic [1:0] I_MEM  = 2'd1;
  localparam logic [1:0] I_DIAG = 2'd2;
  localparam logic [1:0] I_MEAS = 2'd3;

  localparam logic [1:0] SUB_NO  = 2'd0;
  localparam logic [1:0] SUB_YES = 2'd1;
  localparam logic [1:0] SUB_DET = 2'd2;

  logic [3:0]    st_r, st_nxt;
  logic [3:0]    ph_r, ph_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic          sat_r, sat_nxt;
  logic          sing_r, sing_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [2:0]    sel_r, sel_nxt;
  logic [1:0]    row_r, row_nxt, col_r, col_nxt;
  word_t         ldv_r, ldv_nxt, z0_r, z0_nxt, z1_r, z1_nxt;
  word_t         a_r, a_nxt;
  acc_t          det_r, det_nxt;
  word_t         o_px_r, o_px_nxt, o_py_r, o_py_nxt;
  word_t         o_vx_r, o_vx_nxt, o_vy_r, o_vy_nxt;
  logic [1:0]    o_st_r, o_st_nxt;
  word_t         x_sh_r [4];
  logic [USER_D-1:0] valid_r;
  logic          zero_q_r;

  logic [CW-1:0] d_ni, d_nj, d_nk;
  logic [AW-1:0] a_base, a_si, b_base, b_sj, b_sk, i_base, i_si, w_base, w_si;
  logic [1:0]    b_mode, i_mode, sub_mode;

  logic [AW-1:0] addr_a, addr_b, addr_i, addr_w, adj_off, ld_addr;
  logic          ld_ok;
  logic [AW-1:0] ram_raddr, ram_waddr, x_off;
  logic          ram_we;
  word_t         ram_wdata, ram_rdata, rd_val;
  logic signed [32:0] b_val;
  word_t         init_val;
  mac_ctl_t      mac_ctl;
  acc_t          mac_acc;
  word_t         mac_sat_val, div_quo;
  logic          mac_sat, div_start, div_done, div_sat;
  logic          last_elem;

  always_comb begin
    d_ni = CW'(1); d_nj = CW'(1); d_nk = '0;
    a_base = '0; a_si = '0;
    b_base = '0; b_sj = '0; b_sk = AW'(1); b_mode = B_MEM;
    i_mode = I_ZERO; i_base = '0; i_si = '0;
    sub_mode = SUB_NO; w_base = '0; w_si = '0;
    unique case (ph_r)
      PH_FX: begin
        d_ni = CW'(N); d_nk = CW'(N);
        a_base = AW'(A_F); a_si = AW'(N); b_base = AW'(A_X);
        w_base = AW'(A_FX); w_si = AW'(1);
      end
      PH_FP: begin
        d_ni = CW'(N); d_nj = CW'(N); d_nk = CW'(N);
        a_base = AW'(A_F); a_si = AW'(N);
        b_base = AW'(A_P); b_sj = AW'(1); b_sk = AW'(N);
        w_base = AW'(A_FP); w_si = AW'(N);
      end
      PH_PP: begin
        d_ni = CW'(N); d_nj = CW'(N); d_nk = CW'(N);
        i_mode = I_MEM; i_base = AW'(A_Q); i_si = AW'(N);
        a_base = AW'(A_FP); a_si = AW'(N);
        b_base = AW'(A_F); b_sj = AW'(N); b_sk = AW'(1);
        w_base = AW'(A_P); w_si = AW'(N);
      end
      PH_XC: begin
        d_ni = CW'(N);
        i_mode = I_MEM; i_base = AW'(A_FX); i_si = AW'(1);
        w_base = AW'(A_X); w_si = AW'(1);
      end
      PH_Y: begin
        d_ni = CW'(M); d_nk = CW'(N);
        i_mode = I_MEAS; sub_mode = SUB_YES;
        a_base = AW'(A_H); a_si = AW'(N); b_base = AW'(A_X);
        w_base = AW'(A_Y); w_si = AW'(1);
      end
      PH_PH: begin
        d_ni = CW'(N); d_nj = CW'(M); d_nk = CW'(N);
        a_base = AW'(A_P); a_si = AW'(N);
        b_base = AW'(A_H); b_sj = AW'(N); b_sk = AW'(1);
        w_base = AW'(A_PH); w_si = AW'(M);
      end
      PH_S: begin
        d_ni = CW'(M); d_nj = CW'(M); d_nk = CW'(N);
        i_mode = I_MEM; i_base = AW'(A_R); i_si = AW'(M);
        a_base = AW'(A_H); a_si = AW'(N);
        b_base = AW'(A_PH); b_sj = AW'(1); b_sk = AW'(M);
        w_base = AW'(A_S); w_si = AW'(M);
      end
      PH_DET: begin
        d_nk = (M == 2) ? CW'(2) : '0;
        i_mode = (M == 2) ? I_ZERO : I_MEM; i_base = AW'(A_S);
        a_base = AW'(A_S); b_mode = B_DET; sub_mode = SUB_DET;
      end
      PH_K: begin
        d_ni = CW'(N); d_nj = CW'(M); d_nk = CW'(M);
        a_base = AW'(A_PH); a_si = AW'(M);
        b_mode = (M == 2) ? B_ADJ : B_ONE;
        w_base = AW'(A_K); w_si = AW'(M);
      end
      PH_IKH: begin
        d_ni = CW'(N); d_nj = CW'(N); d_nk = CW'(M);
        i_mode = I_DIAG; sub_mode = SUB_YES;
        a_base = AW'(A_K); a_si = AW'(M);
        b_base = AW'(A_H); b_sj = AW'(1); b_sk = AW'(N);
        w_base = AW'(A_IKH); w_si = AW'(N);
      end
      PH_NP: begin
        d_ni = CW'(N); d_nj = CW'(N); d_nk = CW'(N);
        a_base = AW'(A_IKH); a_si = AW'(N);
        b_base = AW'(A_P); b_sj = AW'(1); b_sk = AW'(N);
        w_base = AW'(A_NP); w_si = AW'(N);
      end
      PH_XU: begin
        d_ni = CW'(N); d_nk = CW'(M);
        i_mode = I_MEM; i_base = AW'(A_X); i_si = AW'(1);
        a_base = AW'(A_K); a_si = AW'(M); b_base = AW'(A_Y);
        w_base = AW'(A_X); w_si = AW'(1);
      end
      PH_PC: begin
        d_ni = CW'(N); d_nj = CW'(N);
        i_mode = I_MEM; i_base = AW'(A_NP); i_si = AW'(N);
        w_base = AW'(A_P); w_si = AW'(N);
      end
      default: begin
        d_nk = '0;
      end
    endcase
  end

  assign addr_a  = a_base + AW'(i_r) * a_si + AW'(k_r);
  assign addr_i  = i_base + AW'(i_r) * i_si + AW'(j_r);
  assign addr_w  = w_base + AW'(i_r) * w_si + AW'(j_r);
  assign adj_off = AW'(k_r) * AW'(M) + AW'(j_r);

  always_comb begin
    unique case (b_mode)
      B_MEM: addr_b = b_base + AW'(j_r) * b_sj + AW'(k_r) * b_sk;
      B_ADJ: addr_b = (k_r == j_r) ? AW'(A_S + MM - 1) - adj_off : AW'(A_S) + adj_off;
      B_DET: addr_b = AW'(A_S + MM - 1) - AW'(k_r);
      default: addr_b = AW'(A_S);
    endcase
  end

  assign rd_val = zero_q_r ? '0 : ram_rdata;

  always_comb begin
    unique case (b_mode)
      B_ADJ: b_val = (k_r == j_r) ? {rd_val[31], rd_val} : -{rd_val[31], rd_val};
      B_ONE: b_val = {ONE_Q[31], ONE_Q};
      default: b_val = {rd_val[31], rd_val};
    endcase
  end

  always_comb begin
    unique case (i_mode)
      I_MEM:  init_val = rd_val;
      I_DIAG: init_val = (i_r == j_r) ? ONE_Q : '0;
      I_MEAS: init_val = (i_r == '0) ? z0_r : z1_r;
      default: init_val = '0;
    endcase
  end

  always_comb begin
    ld_ok   = 1'b0;
    ld_addr = '0;
    unique case (sel_r)
      SEL_TRANS: begin
        ld_ok   = (32'(row_r) < 32'(N)) && (32'(col_r) < 32'(N));
        ld_addr = AW'(A_F) + AW'(row_r) * AW'(N) + AW'(col_r);
      end
      SEL_PNOISE: begin
        ld_ok   = (32'(row_r) < 32'(N)) && (32'(col_r) < 32'(N));
        ld_addr = AW'(A_Q) + AW'(row_r) * AW'(N) + AW'(col_r);
      end
      SEL_MEAS: begin
        ld_ok   = (32'(row_r) < 32'(M)) && (32'(col_r) < 32'(N));
        ld_addr = AW'(A_H) + AW'(row_r) * AW'(N) + AW'(col_r);
      end
      SEL_MNOISE: begin
        ld_ok   = (32'(row_r) < 32'(M)) && (32'(col_r) < 32'(M));
        ld_addr = AW'(A_R) + AW'(row_r) * AW'(M) + AW'(col_r);
      end
      SEL_COV: begin
        ld_ok   = (32'(row_r) < 32'(N)) && (32'(col_r) < 32'(N));
        ld_addr = AW'(A_P) + AW'(row_r) * AW'(N) + AW'(col_r);
      end
      SEL_STATE: begin
        ld_ok   = 32'(row_r) < 32'(N);
        ld_addr = AW'(A_X) + AW'(row_r);
      end
      default: ld_ok = 1'b0;
    endcase
  end

  assign last_elem = (j_r == d_nj - 1'b1) && (i_r == d_ni - 1'b1);
  assign in_ready  = (st_r == S_IDLE);
  assign div_start = (st_r == S_FIN) && (ph_r == PH_K);

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    sat_nxt = sat_r; sing_nxt = sing_r; ov_nxt = ov_r;
    kind_nxt = kind_r; sel_nxt = sel_r; row_nxt = row_r; col_nxt = col_r;
    ldv_nxt = ldv_r; z0_nxt = z0_r; z1_nxt = z1_r;
    a_nxt = a_r; det_nxt = det_r;
    o_px_nxt = o_px_r; o_py_nxt = o_py_r; o_vx_nxt = o_vx_r; o_vy_nxt = o_vy_r;
    o_st_nxt = o_st_r;
    ram_raddr = '0; ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;
    mac_ctl = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind; sel_nxt = in_matrix_select;
          row_nxt = in_row_index; col_nxt = in_col_index; ldv_nxt = in_load_value;
          z0_nxt = in_meas_first; z1_nxt = in_meas_second;
          sat_nxt = 1'b0; sing_nxt = 1'b0;
          i_nxt = '0; j_nxt = '0; k_nxt = '0;
          priority case (in_kind)
            KIND_LOAD: st_nxt = S_LOAD;
            KIND_PRED: begin
              ph_nxt = PH_FX; st_nxt = S_INIT;
            end
            KIND_UPD: begin
              ph_nxt = PH_Y; st_nxt = S_INIT;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        ram_we = ld_ok; ram_waddr = ld_addr; ram_wdata = ldv_r;
        st_nxt = S_DONE;
      end
      S_INIT: begin
        ram_raddr = addr_i;
        if (i_mode == I_MEM) begin
          st_nxt = S_INITW;
        end else begin
          mac_ctl.init = 1'b1;
          st_nxt = (d_nk == '0) ? S_FIN : S_RA;
        end
      end
      S_INITW: begin
        mac_ctl.init = 1'b1;
        st_nxt = (d_nk == '0) ? S_FIN : S_RA;
      end
      S_RA: begin
        ram_raddr = addr_a; st_nxt = S_RB;
      end
      S_RB: begin
        a_nxt = rd_val; ram_raddr = addr_b; st_nxt = S_MUL;
      end
      S_MUL: begin
        mac_ctl.mul = 1'b1; st_nxt = S_ACC;
      end
      S_ACC: begin
        mac_ctl.acc = 1'b1;
        mac_ctl.sub = (sub_mode == SUB_YES) || ((sub_mode == SUB_DET) && (k_r != '0));
        if (k_r == d_nk - 1'b1) begin
          k_nxt = '0; st_nxt = S_FIN;
        end else begin
          k_nxt = k_r + 1'b1; st_nxt = S_RA;
        end
      end
      S_FIN, S_DIV: begin
        if (st_r == S_FIN && ph_r == PH_DET) begin
          det_nxt = mac_acc;
        end else if (st_r == S_FIN && ph_r == PH_K) begin
          sat_nxt = sat_r | mac_sat;
        end else begin
          ram_we    = (st_r == S_FIN) || div_done;
          ram_waddr = addr_w;
          ram_wdata = (st_r == S_FIN) ? mac_sat_val : div_quo;
          if (st_r == S_FIN) begin
            sat_nxt = sat_r | mac_sat;
          end else if (div_done) begin
            sat_nxt = sat_r | div_sat;
          end
        end
        if (st_r == S_FIN && ph_r == PH_K) begin
          st_nxt = S_DIV;
        end else if (st_r == S_DIV && !div_done) begin
          st_nxt = S_DIV;
        end else if (ph_r == PH_DET && mac_acc == '0) begin
          sing_nxt = 1'b1; st_nxt = S_DONE;
        end else begin
          st_nxt = S_INIT;
          if (j_r == d_nj - 1'b1) begin
            j_nxt = '0;
            i_nxt = (i_r == d_ni - 1'b1) ? '0 : i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          if (last_elem) begin
            if (ph_r == PH_XC || ph_r == PH_PC) begin
              st_nxt = S_DONE;
            end else begin
              ph_nxt = ph_r + 4'd1;
            end
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          o_px_nxt = x_sh_r[0]; o_py_nxt = x_sh_r[1];
          o_vx_nxt = x_sh_r[2]; o_vy_nxt = x_sh_r[3];
          o_st_nxt = sing_r ? STAT_SING : (sat_r ? STAT_SAT : STAT_OK);
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign x_off = ram_waddr - AW'(A_X);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_FX;
      i_r <= '0; j_r <= '0; k_r <= '0;
      sat_r <= 1'b0; sing_r <= 1'b0; ov_r <= 1'b0;
      valid_r <= '0; zero_q_r <= 1'b1;
      for (int n = 0; n < 4; n++) begin
        x_sh_r[n] <= '0;
      end
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt;
      i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
      sat_r <= sat_nxt; sing_r <= sing_nxt; ov_r <= ov_nxt;
      zero_q_r <= (ram_raddr < AW'(USER_D)) && !valid_r[ram_raddr[UW-1:0]];
      if (ram_we && ram_waddr < AW'(USER_D)) begin
        valid_r[ram_waddr[UW-1:0]] <= 1'b1;
      end
      if (ram_we && ram_waddr >= AW'(A_X) && x_off < AW'(XS)) begin
        x_sh_r[x_off[1:0]] <= ram_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; sel_r <= sel_nxt; row_r <= row_nxt; col_r <= col_nxt;
    ldv_r <= ldv_nxt; z0_r <= z0_nxt; z1_r <= z1_nxt;
    a_r <= a_nxt; det_r <= det_nxt;
    o_px_r <= o_px_nxt; o_py_r <= o_py_nxt; o_vx_r <= o_vx_nxt; o_vy_r <= o_vy_nxt;
    o_st_r <= o_st_nxt;
  end

  kfpu_ram #(.WIDTH(DATA_W), .DEPTH(RAM_D)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kfpu_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .init_val (init_val),
    .a        (a_r),
    .b        (b_val),
    .acc      (mac_acc),
    .sat_val  (mac_sat_val),
    .sat      (mac_sat)
  );

  kfpu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mac_sat_val),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  assign out_valid     = ov_r;
  assign out_est_pos_x = o_px_r;
  assign out_est_pos_y = o_py_r;
  assign out_est_vel_x = o_vx_r;
  assign out_est_vel_y = o_vy_r;
  assign out_status    = o_st_r;

  `KFPU_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `KFPU_ASSERT_IMP(a_div_nonzero, div_start, det_r != '0)
  `KFPU_ASSERT_IMP(a_idle_no_write, st_r == S_IDLE, !ram_we)

endmodule

@@ hw/rtl/kfpu_ram.sv @@
module kfpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/kfpu_mac.sv @@
module kfpu_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  kfpu_pkg::mac_ctl_t  ctl,
  input  kfpu_pkg::word_t     init_val,
  input  kfpu_pkg::word_t     a,
  input  logic signed [32:0]  b,
  output kfpu_pkg::acc_t      acc,
  output kfpu_pkg::word_t     sat_val,
  output logic                sat
);
  import kfpu_pkg::*;

  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);
  localparam acc_t MAX_W = 64'sd2147483647;
  localparam acc_t MIN_W = -64'sd2147483648;

  logic signed [64:0] prod_r;
  logic signed [64:0] prod_nxt;
  logic signed [64:0] rnd;
  acc_t               acc_r;

  assign prod_nxt = a * b;
  assign rnd      = (prod_r + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= prod_nxt;
    end
    if (ctl.init) begin
      acc_r <= ACC_W'(init_val);
    end else if (ctl.acc) begin
      if (ctl.sub) begin
        acc_r <= acc_r - ACC_W'(rnd);
      end else begin
        acc_r <= acc_r + ACC_W'(rnd);
      end
    end
  end

  always_comb begin
    sat     = 1'b1;
    sat_val = word_t'(acc_r[DATA_W-1:0]);
    if (acc_r > MAX_W) begin
      sat_val = word_t'(MAX_W[DATA_W-1:0]);
    end else if (acc_r < MIN_W) begin
      sat_val = word_t'(MIN_W[DATA_W-1:0]);
    end else begin
      sat = 1'b0;
    end
  end

  assign acc = acc_r;

endmodule

@@ hw/rtl/kfpu_div.sv @@
module kfpu_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  kfpu_pkg::word_t num,
  input  kfpu_pkg::acc_t  den,
  output logic            done,
  output kfpu_pkg::word_t quo,
  output logic            sat
);
  import kfpu_pkg::*;

  localparam int DW = DATA_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [ACC_W:0]   rem_r;
  logic [DW-1:0]    dvd_r;
  logic [ACC_W-1:0] den_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;

  logic [ACC_W:0]   rem_sh;
  logic             take;
  logic [DATA_W-1:0] num_mag;
  logic [DW-1:0]    big_max;

  assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
  assign rem_sh  = {rem_r[ACC_W-1:0], dvd_r[DW-1]};
  assign take    = rem_sh >= {1'b0, den_r};
  assign big_max = DW'({1'b0, {(DATA_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
      den_r <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      neg_r <= num[DATA_W-1] ^ den[ACC_W-1];
    end else if (run_r) begin
      rem_r <= take ? (rem_sh - {1'b0, den_r}) : rem_sh;
      dvd_r <= {dvd_r[DW-2:0], take};
    end
  end

  always_comb begin
    sat = 1'b0;
    quo = neg_r ? word_t'(-dvd_r[DATA_W-1:0]) : word_t'(dvd_r[DATA_W-1:0]);
    if (!neg_r && dvd_r > big_max) begin
      sat = 1'b1;
      quo = word_t'({1'b0, {(DATA_W-1){1'b1}}});
    end else if (neg_r && dvd_r > big_max + DW'(1)) begin
      sat = 1'b1;
      quo = word_t'({1'b1, {(DATA_W-1){1'b0}}});
    end
  end

  assign done = done_r;

endmodule
